### design/assert_macros.svh
// Assertion helpers for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define BBA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that one condition implies another in the same cycle
`define BBA_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that one condition implies another in the next cycle
`define BBA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

### design/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared types, codes and defaults of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int LEVELS_DEFAULT = 10;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_SHIFT  = 2'd1;

  localparam logic [31:0] BASE_ADDRESS_RESET = 32'd0;
  localparam logic [4:0]  CHUNK_SHIFT_RESET  = 5'd12;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam int NODE_W = 2;
  localparam logic [NODE_W-1:0] NODE_FREE  = 2'd0;
  localparam logic [NODE_W-1:0] NODE_SPLIT = 2'd1;
  localparam logic [NODE_W-1:0] NODE_OCC   = 2'd2;

  localparam int OWNER_W = 16;

  typedef struct packed {
    logic [OWNER_W-1:0] owner_id;
    logic [31:0]        request_size;
  } bba_in_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } bba_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_BACK,
    ST_FINISH
  } bba_state_t;

endpackage

### design/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/buddy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Grants power-of-two blocks out of a binary buddy tree held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_stall/in_data as one transaction each
//   (owner id and byte count); every request gives exactly one result
//   transaction on out_valid/out_stall/out_data (block address and status).
//   cfg_valid/cfg_ready/cfg_index/cfg_data write base_address (index 0) and
//   chunk_shift (index 1); write them only while the block is idle.
//   An invalid request goes from idle to the finish state and then to the
//   output register. A valid one passes through a RAM read state and an
//   evaluate state per tree node read, plus the backtrack state once per
//   backtracking step, and idle on entry and finish on exit; a worst-case
//   search runs over the whole tree. The single read port of the node
//   state RAM sets this pace: one node is visited at a time.
//   One request is in flight at a time; the next is taken once the current
//   result has moved to the output register, even if that is still stalled.
//   After reset the block sweeps all 2^(LEVELS+1)-1 entries of the node
//   state RAM (2047 at LEVELS=10) to free, one node a cycle, holding
//   in_stall high; configuration writes are taken throughout.
//   A stalled result holds in the output register until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module buddy_block_allocator_unit #(
  parameter int LEVELS = bba_pkg::LEVELS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bba_pkg::bba_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bba_pkg::bba_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bba_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data
);
  import bba_pkg::*;

  // Tree geometry
  localparam int IW    = LEVELS + 1;
  localparam int NODES = (1 << (LEVELS + 1)) - 1;
  localparam int LW    = $clog2(LEVELS + 1);
  localparam int KW    = $clog2(31 + LEVELS + 1);

  bba_state_t state_r, state_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [IW-1:0]      clr_r, clr_nxt;
  logic [OWNER_W-1:0] owner_r, owner_nxt;
  logic [31:0]        req_r, req_nxt;
  logic [31:0]        res_addr_r, res_addr_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  bba_out_t           out_data_r, out_data_nxt;
  logic [31:0]        base_r;
  logic [4:0]         chunk_r;

  // Node state RAM ports
  logic               st_wr_en;
  logic [IW-1:0]      st_wr_addr;
  logic [NODE_W-1:0]  st_wr_data;
  logic [NODE_W-1:0]  st_rd_data;
  logic               own_wr_en;

  // Block size of the current node is 2^blk_k bytes
  logic [KW-1:0]      blk_k;
  logic [32:0]        size33;
  logic [33:0]        size34;
  logic               fits;
  logic               fits_twice;
  logic [IW-1:0]      pos;
  logic [31:0]        offset;

  bba_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_state_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (idx_r),
    .rd_data (st_rd_data)
  );

  // Owner store is written on every grant; nothing in this block reads it
  bba_ram #(.WIDTH(OWNER_W), .DEPTH(NODES)) u_owner_ram (
    .clk     (clk),
    .wr_en   (own_wr_en),
    .wr_addr (idx_r),
    .wr_data (owner_r),
    .rd_addr (idx_r),
    .rd_data ()
  );

  assign blk_k      = KW'(chunk_r) + KW'(LEVELS) - KW'(lvl_r);
  assign size33     = 33'(1) << blk_k;
  assign size34     = 34'(1) << blk_k;
  assign fits       = (blk_k > KW'(32)) || (size33 >= {1'b0, req_r});
  assign fits_twice = (blk_k > KW'(33)) || (size34 >= {1'b0, req_r, 1'b0});

  // Position of the node within its level, scaled by its block size
  assign pos    = idx_r + IW'(1) - (IW'(1) << lvl_r);
  assign offset = 32'(pos) << blk_k;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    lvl_nxt        = lvl_r;
    clr_nxt        = clr_r;
    owner_nxt      = owner_r;
    req_nxt        = req_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    st_wr_en       = 1'b0;
    st_wr_addr     = idx_r;
    st_wr_data     = NODE_FREE;
    own_wr_en      = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep every node to free
        st_wr_en   = 1'b1;
        st_wr_addr = clr_r;
        clr_nxt    = clr_r + IW'(1);
        if (clr_r == IW'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          owner_nxt = in_data.owner_id;
          req_nxt   = in_data.request_size;
          idx_nxt   = '0;
          lvl_nxt   = '0;
          if (in_data.owner_id == '0 || in_data.request_size == '0) begin
            res_status_nxt = STATUS_INVALID;
            res_addr_nxt   = '0;
            state_nxt      = ST_FINISH;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        case (st_rd_data)
          NODE_FREE: begin
            if (lvl_r != LW'(LEVELS) && fits_twice) begin
              // Split; the children of a free node are free already
              st_wr_en   = 1'b1;
              st_wr_data = NODE_SPLIT;
              idx_nxt    = {idx_r[IW-2:0], 1'b1};
              lvl_nxt    = lvl_r + LW'(1);
              state_nxt  = ST_READ;
            end else if (fits) begin
              st_wr_en       = 1'b1;
              st_wr_data     = NODE_OCC;
              own_wr_en      = 1'b1;
              res_status_nxt = STATUS_OK;
              res_addr_nxt   = base_r + offset;
              state_nxt      = ST_FINISH;
            end else begin
              state_nxt = ST_BACK;
            end
          end
          NODE_SPLIT: begin
            if (lvl_r != LW'(LEVELS)) begin
              idx_nxt   = {idx_r[IW-2:0], 1'b1};
              lvl_nxt   = lvl_r + LW'(1);
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_BACK;
            end
          end
          default: begin
            state_nxt = ST_BACK;
          end
        endcase
      end
      ST_BACK: begin
        if (idx_r == '0) begin
          res_status_nxt = STATUS_NOSPACE;
          res_addr_nxt   = '0;
          state_nxt      = ST_FINISH;
        end else if (idx_r[0]) begin
          // Left child done: advance to its right sibling
          idx_nxt   = idx_r + IW'(1);
          state_nxt = ST_READ;
        end else begin
          // Right child done: climb to the parent
          idx_nxt = IW'((idx_r - IW'(1)) >> 1);
          lvl_nxt = lvl_r - LW'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.block_address = res_addr_r;
          out_data_nxt.status        = res_status_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_ADDRESS_RESET;
      chunk_r     <= CHUNK_SHIFT_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BASE_ADDRESS: base_r  <= cfg_data;
          CFG_CHUNK_SHIFT:  chunk_r <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    lvl_r        <= lvl_nxt;
    owner_r      <= owner_nxt;
    req_r        <= req_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Hold the input side while the RAM sweep runs
  `BBA_ASSERT_IMPL(a_clear_stalls, clk, rst_n, state_r == ST_CLEAR, in_stall, "request taken during clear")

  // An invalid request goes straight to the result stage
  `BBA_ASSERT_NEXT(a_invalid_direct, clk, rst_n, in_valid && !in_stall && (in_data.owner_id == '0 || in_data.request_size == '0), state_r == ST_FINISH && res_status_r == STATUS_INVALID, "invalid request not flagged")

  // A refused request never carries an address
  `BBA_ASSERT_IMPL(a_refused_zero, clk, rst_n, out_valid && out_data.status != STATUS_OK, out_data.block_address == '0, "address on refused request")

  // Tree writes stay inside the node range
  `BBA_ASSERT_IMPL(a_write_range, clk, rst_n, st_wr_en, st_wr_addr <= IW'(NODES - 1), "node write out of range")

endmodule
